// ===== rtl/gfdl_pkg.sv =====
// Shared constants, register codes and types for the gliding feedback delay line.
// No dependencies; the top level and gfdl_div import this package.
package gfdl_pkg;

    localparam int LINE_LENGTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int OFS_W   = 32;
    localparam int STEP_W  = 33;
    localparam int GLIDE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int MIX_W   = 17;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [OFS_W-1:0]   OFS_ONE   = 32'h0001_0000;
    localparam logic [OFS_W-1:0]   DELAY_RST = 32'h0001_0000;
    localparam logic [GLIDE_W-1:0] GLIDE_RST = 16'd2205;
    localparam logic [GAIN_W-1:0]  FB_MAX    = 16'd62259;
    localparam logic [MIX_W-1:0]   MIX_FULL  = 17'h1_0000;

    typedef enum logic [1:0] {
        REG_DELAY    = 2'd0,
        REG_GLIDE    = 2'd1,
        REG_FEEDBACK = 2'd2,
        REG_MIX      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [STEP_W-1:0] step;
    } t_div_stat;

endpackage

// ===== rtl/gliding_feedback_delay_line_top.sv =====
// Top level of the gliding feedback delay line: APB registers, sequencer, echo memory.
// Depends on gfdl_pkg, gfdl_div and gfdl_mul.
//
//  port group   | direction | content
//  s_axis_*     | in        | request: sample_in
//  m_axis_*     | out       | result: sample_out
//  APB (p*)     | in/out    | delay_frames, glide_frames, feedback_gain, wet_mix
//
// An item runs from acceptance to the next ready through one glide update, two line
// reads through the single read port and three products through the one shared multiplier.
// The result is registered on leaving S_OUT; a stalled result holds the sequencer in S_OUT.
// After reset a clearing pass writes LINE_LENGTH zeros, one entry a cycle, before ready.
// Each delay write after the first runs the glide divider; the block is not ready while it is busy.
module gliding_feedback_delay_line_top import gfdl_pkg::*; #(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_in, zero padding above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero padding above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [APB_AW-1:0]                      paddr,
    input  logic [APB_DW-1:0]                      pwdata,
    output logic [APB_DW-1:0]                      prdata,
    output logic                                   pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int TD_W  = ((SB + 7) / 8) * 8;
    localparam int IDX_W = $clog2(LINE_LENGTH);
    localparam int PW    = IDX_W + 17;
    localparam int PW1   = PW - 1;
    localparam int MA_W  = SB + 1;
    localparam int MB_W  = 18;
    localparam int MP_W  = MA_W + MB_W;
    localparam int SH_W  = MP_W - 16;

    localparam logic [63:0]      HI_FULL  = 64'(LINE_LENGTH - 1) << 16;
    localparam logic [OFS_W-1:0] OFS_HI   = (HI_FULL > 64'hFFFF_FFFF) ? '1
                                                                      : HI_FULL[OFS_W-1:0];
    localparam logic [PW-1:0]    LEN_Q    = PW'(64'(LINE_LENGTH) << 16);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINE_LENGTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_GLIDE, S_POS, S_RD0, S_RD1, S_MUL1, S_WET, S_MUL2, S_MUL3, S_OUT
    } t_state;

    t_state                   r_state;
    logic                     r_clr;
    logic [IDX_W-1:0]         r_clr_cnt;
    logic [IDX_W-1:0]         r_wr_idx;
    logic [OFS_W-1:0]         r_ro;
    logic [OFS_W-1:0]         r_target;
    logic                     r_unset;
    logic signed [STEP_W-1:0] r_step;
    logic [OFS_W-1:0]         r_delay;
    logic [GLIDE_W-1:0]       r_glide;
    logic [GAIN_W-1:0]        r_fb;
    logic [MIX_W-1:0]         r_mix;
    logic                     r_m_valid;

    logic signed [SB-1:0]     r_x;
    logic [IDX_W-1:0]         r_i0;
    logic [IDX_W-1:0]         r_i1;
    logic [15:0]              r_frac;
    logic signed [SB-1:0]     r_s0;
    logic signed [SB-1:0]     r_rd;
    logic signed [SB-1:0]     r_wet;
    logic [SB-1:0]            r_y;
    logic signed [SB-1:0]     r_mem [LINE_LENGTH];

    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;
    logic [OFS_W-1:0]         want;
    logic                     div_start;
    logic signed [STEP_W-1:0] div_diff;
    logic [GLIDE_W-1:0]       div_dvs;
    t_div_stat                div_stat;

    logic                     in_acc;
    logic                     out_load;
    logic [OFS_W-1:0]         rd_dist;
    logic [PW1-1:0]           dist_ext;
    logic signed [PW-1:0]     pos_raw;
    logic [PW-1:0]            pos;
    logic [IDX_W-1:0]         pos_i0;
    logic [IDX_W-1:0]         pos_i1;
    logic signed [OFS_W+1:0]  g_sum;
    logic signed [OFS_W+1:0]  g_tgt;
    logic                     g_reached;

    logic [GAIN_W-1:0]        fb_c;
    logic [MIX_W-1:0]         mix_c;
    logic                     mul_en;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   prod;
    logic signed [SH_W-1:0]   prod_sh;
    logic signed [SH_W-1:0]   x_ext;
    logic signed [SH_W-1:0]   s0_ext;
    logic signed [SH_W-1:0]   wet_sum;
    logic signed [SH_W-1:0]   wr_sum;
    logic                     wr_ovf;
    logic signed [SB-1:0]     wr_sat;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [IDX_W-1:0]         mem_raddr;
    logic signed [SB-1:0]     mem_wdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        if (pwdata < OFS_ONE) begin
            want = OFS_ONE;
        end else if (pwdata > OFS_HI) begin
            want = OFS_HI;
        end else begin
            want = pwdata;
        end
    end

    assign div_start = cfg_wr && (cfg_idx == REG_DELAY) && !r_unset;
    assign div_diff  = $signed({1'b0, want}) - $signed({1'b0, r_ro});
    assign div_dvs   = (r_glide == '0) ? GLIDE_W'(1) : r_glide;

    gfdl_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_diff    (div_diff),
        .i_divisor (div_dvs),
        .o_stat    (div_stat)
    );

    always_comb begin
        unique case (cfg_idx)
            REG_DELAY:    prdata = r_delay;
            REG_GLIDE:    prdata = APB_DW'(r_glide);
            REG_FEEDBACK: prdata = APB_DW'(r_fb);
            REG_MIX:      prdata = APB_DW'(r_mix);
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr && !div_stat.busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = TD_W'(r_y);

    assign rd_dist  = r_unset ? r_target : r_ro;
    assign dist_ext = PW1'(rd_dist);
    assign pos_raw  = $signed({1'b0, r_wr_idx, 16'b0}) - $signed({1'b0, dist_ext});
    assign pos      = pos_raw[PW-1] ? PW'(pos_raw + $signed(LEN_Q)) : PW'(pos_raw);
    assign pos_i0   = pos[IDX_W+15:16];
    assign pos_i1   = (pos_i0 == IDX_LAST) ? '0 : pos_i0 + 1'b1;

    assign g_sum     = $signed({2'b0, r_ro}) + (OFS_W+2)'(r_step);
    assign g_tgt     = $signed({2'b0, r_target});
    assign g_reached = r_step[STEP_W-1] ? (g_sum <= g_tgt) : (g_sum >= g_tgt);

    assign fb_c  = (r_fb > FB_MAX) ? FB_MAX : r_fb;
    assign mix_c = (r_mix > MIX_FULL) ? MIX_FULL : r_mix;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_MUL1: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(r_rd) - MA_W'(r_s0);
                mul_b  = $signed({2'b0, r_frac});
            end
            S_MUL2: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(r_wet);
                mul_b  = $signed({2'b0, fb_c});
            end
            S_MUL3: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(r_wet) - MA_W'(r_x);
                mul_b  = $signed({1'b0, mix_c});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    gfdl_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign prod_sh = prod[MP_W-1:16];
    assign x_ext   = SH_W'(r_x);
    assign s0_ext  = SH_W'(r_s0);
    assign wet_sum = s0_ext + prod_sh;
    assign wr_sum  = x_ext + prod_sh;
    assign wr_ovf  = !(&wr_sum[SH_W-1:SB-1]) && (|wr_sum[SH_W-1:SB-1]);
    assign wr_sat  = !wr_ovf ? wr_sum[SB-1:0]
                   : (wr_sum[SH_W-1] ? $signed({1'b1, {(SB-1){1'b0}}})
                                     : $signed({1'b0, {(SB-1){1'b1}}}));

    assign mem_we    = r_clr || (r_state == S_MUL3);
    assign mem_waddr = r_clr ? r_clr_cnt : r_wr_idx;
    assign mem_wdata = r_clr ? '0 : wr_sat;
    assign mem_raddr = (r_state == S_RD1) ? r_i1 : r_i0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_wr_idx  <= '0;
            r_ro      <= '0;
            r_target  <= OFS_ONE;
            r_unset   <= 1'b1;
            r_step    <= '0;
            r_delay   <= DELAY_RST;
            r_glide   <= GLIDE_RST;
            r_fb      <= '0;
            r_mix     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == IDX_LAST) begin
                    r_clr <= 1'b0;
                end
            end

            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_DELAY: begin
                        r_delay  <= pwdata;
                        r_target <= want;
                        if (r_unset) begin
                            r_ro    <= want;
                            r_step  <= '0;
                            r_unset <= 1'b0;
                        end
                    end
                    REG_GLIDE:    r_glide <= pwdata[GLIDE_W-1:0];
                    REG_FEEDBACK: r_fb    <= pwdata[GAIN_W-1:0];
                    REG_MIX:      r_mix   <= pwdata[MIX_W-1:0];
                endcase
            end

            if (div_stat.done) begin
                r_step <= div_stat.step;
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_GLIDE;
                    end
                end
                S_GLIDE: begin
                    if (!r_unset && r_step != '0) begin
                        if (g_reached) begin
                            r_ro   <= r_target;
                            r_step <= '0;
                        end else begin
                            r_ro <= g_sum[OFS_W-1:0];
                        end
                    end
                    r_state <= S_POS;
                end
                S_POS:  r_state <= S_RD0;
                S_RD0:  r_state <= S_RD1;
                S_RD1:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_WET;
                S_WET:  r_state <= S_MUL2;
                S_MUL2: r_state <= S_MUL3;
                S_MUL3: begin
                    r_wr_idx <= (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= $signed(s_axis_tdata[SB-1:0]);
        end
        if (r_state == S_POS) begin
            r_i0   <= pos_i0;
            r_i1   <= pos_i1;
            r_frac <= pos[15:0];
        end
        if (r_state == S_RD1) begin
            r_s0 <= r_rd;
        end
        if (r_state == S_WET) begin
            r_wet <= wet_sum[SB-1:0];
        end
        if (out_load) begin
            r_y <= SB'(x_ext + prod_sh);
        end
    end

endmodule

// ===== rtl/gfdl_div.sv =====
// Radix-2 restoring divider for the glide step, one quotient bit per cycle.
// Depends on gfdl_pkg (widths, t_div_stat).
module gfdl_div import gfdl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [STEP_W-1:0] i_diff,
    input  logic [GLIDE_W-1:0]       i_divisor,
    output t_div_stat                o_stat
);

    localparam int CNT_W = $clog2(OFS_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg;
    logic               r_nz;
    logic [GLIDE_W-1:0] r_dvs;
    logic [GLIDE_W-1:0] r_rem;
    logic [OFS_W-1:0]   r_quo;

    logic [STEP_W-1:0]        mag_full;
    logic [GLIDE_W:0]         trial;
    logic [GLIDE_W:0]         trial_sub;
    logic                     ge;
    logic signed [STEP_W-1:0] q_s;

    assign mag_full  = i_diff[STEP_W-1] ? STEP_W'(-i_diff) : STEP_W'(i_diff);
    assign trial     = {r_rem, r_quo[OFS_W-1]};
    assign trial_sub = trial - {1'b0, r_dvs};
    assign ge        = trial >= {1'b0, r_dvs};
    assign q_s       = $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OFS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_diff[STEP_W-1];
            r_nz  <= i_diff != '0;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= mag_full[OFS_W-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? trial_sub[GLIDE_W-1:0] : trial[GLIDE_W-1:0];
            r_quo <= {r_quo[OFS_W-2:0], ge};
        end
    end

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.done = r_done;
        if (r_quo == '0 && r_nz) begin
            o_stat.step = r_neg ? {STEP_W{1'b1}} : STEP_W'(1);
        end else begin
            o_stat.step = r_neg ? -q_s : q_s;
        end
    end

endmodule

// ===== rtl/gfdl_mul.sv =====
// Shared signed multiplier with a registered product and load enable.
// No dependencies.
module gfdl_mul #(
    parameter int A_W = 17,
    parameter int B_W = 18
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/gfdl_checker.sv =====
// Port-level checker for the gliding feedback delay line, bound to the top level.
// Depends on the top level's ports only.
module gfdl_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result raised right after a request");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("ready during line clear");

endmodule

bind gliding_feedback_delay_line_top gfdl_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gfdl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
